// ----- rtl/rprt_pkg.sv -----
// ----------------------------------------------------------------------------
// rprt_pkg
// Shared types and constants of the reserved port range table.
// ----------------------------------------------------------------------------
package rprt_pkg;

  localparam int TABLE_ENTRIES = 16;
  localparam int PORT_W        = 16;

  localparam logic [1:0] OP_ADD   = 2'd0;
  localparam logic [1:0] OP_DEL   = 2'd1;
  localparam logic [1:0] OP_QUERY = 2'd2;
  localparam logic [1:0] OP_RSVD  = 2'd3;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_INVALID   = 2'd1;
  localparam logic [1:0] ST_NOT_FOUND = 2'd2;
  localparam logic [1:0] ST_FULL      = 2'd3;

  typedef struct packed {
    logic [1:0]        operation;
    logic [PORT_W-1:0] range_low;
    logic [PORT_W-1:0] range_high;
    logic [PORT_W-1:0] query_port;
  } req_t;

  typedef struct packed {
    logic [1:0] status;
    logic       is_reserved;
  } rsp_t;

  // Controller to datapath commands
  typedef struct packed {
    logic load;
    logic exec;
  } dp_cmd_t;

endpackage

// ----- rtl/reserved_port_range_table_core.sv -----
// ----------------------------------------------------------------------------
// reserved_port_range_table_core
// Table of reserved port ranges: add, delete and port coverage query.
// ----------------------------------------------------------------------------
//  channel  | ports                      | handshake
//  ---------+----------------------------+-------------------------------
//  request  | start, busy, in_req        | taken when start && !busy
//  result   | out_valid, out_result      | one-cycle strobe, no stall
//
//  Each request is first registered, then runs in an execute cycle in
//  which all slots are compared in parallel and the table is updated.
//  The result strobes in the cycle after the execute cycle, while busy is
//  already low, so a new request can be taken that same cycle.
//  Synchronous active-low reset empties the table; slot ports need no reset.
//  The receiver cannot stall; every result is delivered exactly once.
// ----------------------------------------------------------------------------
module reserved_port_range_table_core (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  output logic           busy,
  input  rprt_pkg::req_t in_req,
  output logic           out_valid,
  output rprt_pkg::rsp_t out_result
);
  import rprt_pkg::*;

  dp_cmd_t cmd;

  rprt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .out_valid (out_valid),
    .cmd       (cmd)
  );

  rprt_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .in_req     (in_req),
    .out_result (out_result)
  );

`ifndef SYNTH
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted request did not raise busy");

  a_exec_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    busy |=> (out_valid && !busy))
    else $error("execute cycle not followed by result strobe");

  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result strobe while busy");

  a_reserved_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_result.is_reserved) |-> (out_result.status == ST_OK))
    else $error("reserved flag with error status");
`endif

endmodule

// ----- rtl/rprt_ctrl.sv -----
// ----------------------------------------------------------------------------
// rprt_ctrl
// Sequencer: takes a request, runs the execute state, strobes the result.
// ----------------------------------------------------------------------------
module rprt_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  output logic              out_valid,
  output rprt_pkg::dp_cmd_t cmd
);
  import rprt_pkg::*;

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        state_nxt     = S_IDLE;
        out_valid_nxt = 1'b1;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign busy      = (state_r == S_EXEC);
  assign out_valid = out_valid_r;

  always_comb begin
    cmd.load = start && (state_r == S_IDLE);
    cmd.exec = (state_r == S_EXEC);
  end

endmodule

// ----- rtl/rprt_dp.sv -----
// ----------------------------------------------------------------------------
// rprt_dp
// Range table storage with parallel compare across all slots.
// ----------------------------------------------------------------------------
module rprt_dp (
  input  logic              clk,
  input  logic              rst_n,
  input  rprt_pkg::dp_cmd_t cmd,
  input  rprt_pkg::req_t    in_req,
  output rprt_pkg::rsp_t    out_result
);
  import rprt_pkg::*;

  req_t              req_r;
  logic [PORT_W-1:0] low_r  [TABLE_ENTRIES];
  logic [PORT_W-1:0] high_r [TABLE_ENTRIES];
  logic [TABLE_ENTRIES-1:0] present_r, present_nxt;
  logic [TABLE_ENTRIES-1:0] live_r, live_nxt;
  rsp_t              rsp_r, rsp_nxt;

  logic [TABLE_ENTRIES-1:0] match_vec;
  logic [TABLE_ENTRIES-1:0] cover_vec;
  logic [TABLE_ENTRIES-1:0] free_vec;
  logic [TABLE_ENTRIES-1:0] first_free;
  logic                     inverted;
  logic                     is_edit;
  logic                     do_insert;

  always_comb begin
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      match_vec[i] = present_r[i] && (low_r[i] == req_r.range_low) &&
                     (high_r[i] == req_r.range_high);
      cover_vec[i] = present_r[i] && live_r[i] && (low_r[i] <= req_r.query_port) &&
                     (req_r.query_port <= high_r[i]);
    end
  end

  assign free_vec   = ~present_r;
  // isolate lowest free slot
  assign first_free = free_vec & (~free_vec + {{(TABLE_ENTRIES-1){1'b0}}, 1'b1});
  assign inverted   = req_r.range_low > req_r.range_high;
  assign is_edit    = (req_r.operation == OP_ADD) || (req_r.operation == OP_DEL);
  assign do_insert  = (req_r.operation == OP_ADD) && !inverted && !(|match_vec) &&
                      (|free_vec);

  always_comb begin
    present_nxt         = present_r;
    live_nxt            = live_r;
    rsp_nxt.status      = ST_OK;
    rsp_nxt.is_reserved = 1'b0;
    case (req_r.operation)
      OP_ADD: begin
        if (inverted) begin
          rsp_nxt.status = ST_INVALID;
        end else if (|match_vec) begin
          live_nxt = live_r | match_vec;
        end else if (|free_vec) begin
          present_nxt = present_r | first_free;
          live_nxt    = live_r | first_free;
        end else begin
          rsp_nxt.status = ST_FULL;
        end
      end
      OP_DEL: begin
        if (inverted) begin
          rsp_nxt.status = ST_INVALID;
        end else if (|match_vec) begin
          live_nxt = live_r & ~match_vec;
        end else begin
          rsp_nxt.status = ST_NOT_FOUND;
        end
      end
      OP_QUERY: begin
        rsp_nxt.is_reserved = |cover_vec;
      end
      OP_RSVD: begin
        rsp_nxt.status = ST_INVALID;
      end
      default: begin
        rsp_nxt.status = ST_INVALID;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      present_r <= '0;
      live_r    <= '0;
    end else if (cmd.exec && is_edit) begin
      present_r <= present_nxt;
      live_r    <= live_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_r <= in_req;
    end
    if (cmd.exec) begin
      rsp_r <= rsp_nxt;
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
        if (do_insert && first_free[i]) begin
          low_r[i]  <= req_r.range_low;
          high_r[i] <= req_r.range_high;
        end
      end
    end
  end

  assign out_result = rsp_r;

endmodule
